// ----- hw/rtl/dlhc_pkg.sv -----
// dlhc_pkg: shared widths, fixed-point constants, sector codes and stage structs
// for the dB level heat color pipeline. No dependencies.
package dlhc_pkg;

   localparam int unsigned ATT_W   = 10;
   localparam int unsigned RANGE_W = 8;
   localparam int unsigned CHAN_W  = 8;

   // accepting edge to the edge that takes the result
   localparam int unsigned PIPE_LATENCY = 26;

   localparam logic [RANGE_W-1:0] RANGE_RESET = 8'd100;

   // hue span of the level scale, degrees
   localparam logic [7:0]  HUE_SPAN = 8'd180;

   // Q0.16 with one extra bit, 1.0 = 65536
   localparam logic [16:0] ONE_Q16       = 17'd65536;
   localparam logic [15:0] SAT_Q16       = 16'd58982;
   localparam logic [15:0] ONE_MINUS_SAT = 16'd6554;

   // divider step counts: level^2/range^2 quotient and level*180/range quotient
   localparam int unsigned DIV_B_STEPS = 17;
   localparam int unsigned DIV_A_STEPS = 8;

   // HSV sector, floor(hue/60)
   typedef enum logic [2:0] {
      SECT_0 = 3'd0,
      SECT_1 = 3'd1,
      SECT_2 = 3'd2,
      SECT_3 = 3'd3,
      SECT_4 = 3'd4,
      SECT_5 = 3'd5
   } sector_type;

   typedef struct packed {
      logic         valid;
      logic [7:0]   rng;
      logic [15:0]  na;    // level*180
      logic [15:0]  l2;    // level^2
      logic [15:0]  d2;    // range^2
   } front_to_div_type;

   typedef struct packed {
      logic         valid;
      logic [7:0]   tmp;
      logic [16:0]  v;
   } div_to_hue_type;

   typedef struct packed {
      logic         valid;
      logic [16:0]  v;
      sector_type   sector;
      logic [15:0]  sc;
      logic [15:0]  sc2;
   } hue_to_mix_type;

endpackage

// ----- hw/rtl/dlhc_front.sv -----
// dlhc_front: range clamp, attenuation saturation, level and the three small
// products feeding the dividers. Depends on dlhc_pkg.
module dlhc_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  logic [dlhc_pkg::ATT_W-1:0]     in_att,
   input  logic [dlhc_pkg::RANGE_W-1:0]   in_range,
   output dlhc_pkg::front_to_div_type     out
);
   import dlhc_pkg::*;

   logic [RANGE_W-1:0] rng_in;
   logic [RANGE_W-1:0] att_sat_in;
   logic [RANGE_W-1:0] level_in;

   logic               s1_valid_ff;
   logic [RANGE_W-1:0] s1_level_ff;
   logic [RANGE_W-1:0] s1_rng_ff;

   front_to_div_type   s2_in;
   front_to_div_type   s2_ff;

   always_comb begin
      rng_in = (in_range == '0) ? RANGE_W'(1) : in_range;
      if (in_att > ATT_W'(rng_in)) begin
         att_sat_in = rng_in;
      end else begin
         att_sat_in = in_att[RANGE_W-1:0];
      end
      level_in = rng_in - att_sat_in;
   end

   always_comb begin
      s2_in.valid = s1_valid_ff;
      s2_in.rng   = s1_rng_ff;
      s2_in.na    = 16'(s1_level_ff) * 16'(HUE_SPAN);
      s2_in.l2    = 16'(s1_level_ff) * 16'(s1_level_ff);
      s2_in.d2    = 16'(s1_rng_ff) * 16'(s1_rng_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_ff.valid <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_ff       <= s2_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_level_ff <= level_in;
      s1_rng_ff   <= rng_in;
   end

   assign out = s2_ff;

endmodule

// ----- hw/rtl/dlhc_div.sv -----
// dlhc_div: two restoring dividers in lockstep, one quotient bit per stage.
// tmp = level*180/range (8 steps), v = level^2*65536/range^2 (17 steps). Depends on dlhc_pkg.
module dlhc_div (
   input  logic                        clock,
   input  logic                        reset,
   input  dlhc_pkg::front_to_div_type  in,
   output dlhc_pkg::div_to_hue_type    out
);
   import dlhc_pkg::*;

   localparam int unsigned NB = DIV_B_STEPS;
   localparam int unsigned NA = DIV_A_STEPS;

   // long division: level^2 << 16 over range^2
   logic        src_vld  [0:NB-1];
   logic [15:0] src_remb [0:NB-1];
   logic        src_bbit [0:NB-1];
   logic [16:0] src_qb   [0:NB-1];
   logic [15:0] src_d2   [0:NB-1];
   logic [16:0] tb       [0:NB-1];
   logic [16:0] tb_diff  [0:NB-1];
   logic        b_ge     [0:NB-1];
   logic [15:0] remb_in  [0:NB-1];
   logic [16:0] qb_in    [0:NB-1];
   logic        vld_ff   [0:NB-1];
   logic [16:0] qb_ff    [0:NB-1];
   logic [15:0] remb_ff  [0:NB-2];
   logic [15:0] d2_ff    [0:NB-2];

   // short division: level*180 over range
   logic [7:0]  src_qa   [0:NB-1];
   logic [7:0]  qa_in    [0:NB-1];
   logic [7:0]  qa_ff    [0:NB-1];
   logic [7:0]  src_rema [0:NA-1];
   logic [7:0]  src_nalo [0:NA-1];
   logic [7:0]  src_rng  [0:NA-1];
   logic [8:0]  ta       [0:NA-1];
   logic [8:0]  ta_diff  [0:NA-1];
   logic        a_ge     [0:NA-1];
   logic [7:0]  rema_in  [0:NA-1];
   logic [7:0]  nalo_in  [0:NA-1];
   logic [7:0]  rema_ff  [0:NA-2];
   logic [7:0]  nalo_ff  [0:NA-2];
   logic [7:0]  rng_ff   [0:NA-2];

   for (genvar k = 0; k < NB; k++) begin : g_step
      if (k == 0) begin : g_src_first
         // level^2 < 2*range^2, so the top 16 bits start below the divisor
         assign src_vld[k]  = in.valid;
         assign src_remb[k] = {1'b0, in.l2[15:1]};
         assign src_bbit[k] = in.l2[0];
         assign src_qb[k]   = '0;
         assign src_d2[k]   = in.d2;
         assign src_qa[k]   = '0;
      end else begin : g_src_next
         assign src_vld[k]  = vld_ff[k-1];
         assign src_remb[k] = remb_ff[k-1];
         assign src_bbit[k] = 1'b0;
         assign src_qb[k]   = qb_ff[k-1];
         assign src_d2[k]   = d2_ff[k-1];
         assign src_qa[k]   = qa_ff[k-1];
      end

      assign tb[k]      = {src_remb[k], src_bbit[k]};
      assign tb_diff[k] = tb[k] - {1'b0, src_d2[k]};
      assign b_ge[k]    = (tb[k] >= {1'b0, src_d2[k]});
      assign remb_in[k] = b_ge[k] ? tb_diff[k][15:0] : tb[k][15:0];
      assign qb_in[k]   = {src_qb[k][15:0], b_ge[k]};

      if (k < NA) begin : g_a
         if (k == 0) begin : g_a_first
            // quotient < 256, so the high byte starts below the divisor
            assign src_rema[k] = in.na[15:8];
            assign src_nalo[k] = in.na[7:0];
            assign src_rng[k]  = in.rng;
         end else begin : g_a_next
            assign src_rema[k] = rema_ff[k-1];
            assign src_nalo[k] = nalo_ff[k-1];
            assign src_rng[k]  = rng_ff[k-1];
         end

         assign ta[k]      = {src_rema[k], src_nalo[k][7]};
         assign ta_diff[k] = ta[k] - {1'b0, src_rng[k]};
         assign a_ge[k]    = (ta[k] >= {1'b0, src_rng[k]});
         assign rema_in[k] = a_ge[k] ? ta_diff[k][7:0] : ta[k][7:0];
         assign nalo_in[k] = {src_nalo[k][6:0], 1'b0};
         assign qa_in[k]   = {src_qa[k][6:0], a_ge[k]};

         // the last step only hands on its quotient
         if (k < NA - 1) begin : g_a_reg
            always_ff @(posedge clock) begin
               rema_ff[k] <= rema_in[k];
               nalo_ff[k] <= nalo_in[k];
               rng_ff[k]  <= src_rng[k];
            end
         end
      end else begin : g_a_done
         assign qa_in[k] = src_qa[k];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= src_vld[k];
         end
      end

      always_ff @(posedge clock) begin
         qb_ff[k] <= qb_in[k];
         qa_ff[k] <= qa_in[k];
      end

      if (k < NB - 1) begin : g_rem
         always_ff @(posedge clock) begin
            remb_ff[k] <= remb_in[k];
            d2_ff[k]   <= src_d2[k];
         end
      end
   end

   assign out.valid = vld_ff[NB-1];
   assign out.tmp   = qa_ff[NB-1];
   assign out.v     = qb_ff[NB-1];

endmodule

// ----- hw/rtl/dlhc_hue.sv -----
// dlhc_hue: hue from tmp, sector and in-sector fraction C, then the two
// saturation products S*C and S*(1-C). Five stages. Depends on dlhc_pkg.
module dlhc_hue (
   input  logic                      clock,
   input  logic                      reset,
   input  dlhc_pkg::div_to_hue_type  in,
   output dlhc_pkg::hue_to_mix_type  out
);
   import dlhc_pkg::*;

   // floor(u/45) = (u*11651) >> 19 for u < 8192
   localparam logic [13:0] DIV45_MUL   = 14'd11651;
   localparam int unsigned DIV45_SHIFT = 19;
   // floor(r*65536/60) = r*1092 + ((r*1096) >> 12) for r < 60
   localparam logic [10:0] C_MUL_INT   = 11'd1092;
   localparam logic [10:0] C_MUL_FRAC  = 11'd1096;
   localparam int unsigned C_FRAC_SHIFT = 12;
   // hue = (270 + q) mod 360, split by q
   localparam logic [7:0]  Q_SECT4_END = 8'd30;
   localparam logic [7:0]  Q_SECT5_END = 8'd90;
   localparam logic [7:0]  Q_SECT0_END = 8'd150;

   logic        h1_vld_ff;
   logic [15:0] h1_t2_ff;
   logic [16:0] h1_v_ff;

   logic [27:0] q_prod;
   logic [7:0]  q_in;
   logic        h2_vld_ff;
   logic [7:0]  h2_q_ff;
   logic [16:0] h2_v_ff;

   sector_type  sector_in;
   logic [5:0]  rem_in;
   logic        h3_vld_ff;
   sector_type  h3_sector_ff;
   logic [5:0]  h3_rem_ff;
   logic [16:0] h3_v_ff;

   logic [16:0] c_int_prod;
   logic [16:0] c_frac_prod;
   logic [15:0] c_in;
   logic        h4_vld_ff;
   sector_type  h4_sector_ff;
   logic [15:0] h4_c_ff;
   logic [16:0] h4_v_ff;

   logic [31:0] sc_prod;
   logic [16:0] one_minus_c;
   logic [32:0] sc2_prod;
   hue_to_mix_type h5_in;
   hue_to_mix_type h5_ff;

   always_comb begin
      q_prod = 28'(h1_t2_ff[15:2]) * 28'(DIV45_MUL);
      q_in   = q_prod[DIV45_SHIFT+7:DIV45_SHIFT];
   end

   always_comb begin
      if (h2_q_ff < Q_SECT4_END) begin
         sector_in = SECT_4;
         rem_in    = 6'(h2_q_ff + Q_SECT4_END);
      end else if (h2_q_ff < Q_SECT5_END) begin
         sector_in = SECT_5;
         rem_in    = 6'(h2_q_ff - Q_SECT4_END);
      end else if (h2_q_ff < Q_SECT0_END) begin
         sector_in = SECT_0;
         rem_in    = 6'(h2_q_ff - Q_SECT5_END);
      end else begin
         sector_in = SECT_1;
         rem_in    = 6'(h2_q_ff - Q_SECT0_END);
      end
   end

   always_comb begin
      c_int_prod  = 17'(h3_rem_ff) * 17'(C_MUL_INT);
      c_frac_prod = 17'(h3_rem_ff) * 17'(C_MUL_FRAC);
      c_in        = c_int_prod[15:0] + 16'(c_frac_prod[16:C_FRAC_SHIFT]);
   end

   always_comb begin
      sc_prod      = 32'(SAT_Q16) * 32'(h4_c_ff);
      one_minus_c  = ONE_Q16 - 17'(h4_c_ff);
      sc2_prod     = 33'(SAT_Q16) * 33'(one_minus_c);
      h5_in.valid  = h4_vld_ff;
      h5_in.v      = h4_v_ff;
      h5_in.sector = h4_sector_ff;
      h5_in.sc     = sc_prod[31:16];
      h5_in.sc2    = sc2_prod[31:16];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h1_vld_ff   <= 1'b0;
         h2_vld_ff   <= 1'b0;
         h3_vld_ff   <= 1'b0;
         h4_vld_ff   <= 1'b0;
         h5_ff.valid <= 1'b0;
      end else begin
         h1_vld_ff   <= in.valid;
         h2_vld_ff   <= h1_vld_ff;
         h3_vld_ff   <= h2_vld_ff;
         h4_vld_ff   <= h3_vld_ff;
         h5_ff       <= h5_in;
      end
   end

   always_ff @(posedge clock) begin
      h1_t2_ff     <= 16'(in.tmp) * 16'(in.tmp);
      h1_v_ff      <= in.v;
      h2_q_ff      <= q_in;
      h2_v_ff      <= h1_v_ff;
      h3_sector_ff <= sector_in;
      h3_rem_ff    <= rem_in;
      h3_v_ff      <= h2_v_ff;
      h4_sector_ff <= h3_sector_ff;
      h4_c_ff      <= c_in;
      h4_v_ff      <= h3_v_ff;
   end

   assign out = h5_ff;

endmodule

// ----- hw/rtl/dlhc_mix.sv -----
// dlhc_mix: X/Y/Z channel products, sector selection and byte scaling.
// Two stages, the second is the result register. Depends on dlhc_pkg.
module dlhc_mix (
   input  logic                        clock,
   input  logic                        reset,
   input  dlhc_pkg::hue_to_mix_type    in,
   output logic                        out_valid,
   output logic [dlhc_pkg::CHAN_W-1:0] out_red,
   output logic [dlhc_pkg::CHAN_W-1:0] out_green,
   output logic [dlhc_pkg::CHAN_W-1:0] out_blue
);
   import dlhc_pkg::*;

   // floor(val*255/65536), val <= 65536
   function automatic logic [CHAN_W-1:0] to_byte(input logic [16:0] val);
      logic [24:0] scaled;
      scaled = {val, 8'b0} - 25'(val);
      return scaled[23:16];
   endfunction

   logic [16:0] one_minus_sc;
   logic [16:0] one_minus_sc2;
   logic [32:0] x_prod;
   logic [33:0] y_prod;
   logic [33:0] z_prod;

   logic        m1_vld_ff;
   sector_type  m1_sector_ff;
   logic [16:0] m1_v_ff;
   logic [16:0] m1_x_ff;
   logic [16:0] m1_y_ff;
   logic [16:0] m1_z_ff;

   logic [16:0] r_val;
   logic [16:0] g_val;
   logic [16:0] b_val;

   logic              m2_vld_ff;
   logic [CHAN_W-1:0] m2_red_ff;
   logic [CHAN_W-1:0] m2_green_ff;
   logic [CHAN_W-1:0] m2_blue_ff;

   always_comb begin
      one_minus_sc  = ONE_Q16 - 17'(in.sc);
      one_minus_sc2 = ONE_Q16 - 17'(in.sc2);
      x_prod        = 33'(in.v) * 33'(ONE_MINUS_SAT);
      y_prod        = 34'(in.v) * 34'(one_minus_sc);
      z_prod        = 34'(in.v) * 34'(one_minus_sc2);
   end

   always_comb begin
      case (m1_sector_ff)
         SECT_0: begin
            r_val = m1_v_ff; g_val = m1_z_ff; b_val = m1_x_ff;
         end
         SECT_1: begin
            r_val = m1_y_ff; g_val = m1_v_ff; b_val = m1_x_ff;
         end
         SECT_2: begin
            r_val = m1_x_ff; g_val = m1_v_ff; b_val = m1_z_ff;
         end
         SECT_3: begin
            r_val = m1_x_ff; g_val = m1_y_ff; b_val = m1_v_ff;
         end
         SECT_4: begin
            r_val = m1_z_ff; g_val = m1_x_ff; b_val = m1_v_ff;
         end
         default: begin
            r_val = m1_v_ff; g_val = m1_x_ff; b_val = m1_y_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_vld_ff <= 1'b0;
         m2_vld_ff <= 1'b0;
      end else begin
         m1_vld_ff <= in.valid;
         m2_vld_ff <= m1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      m1_sector_ff <= in.sector;
      m1_v_ff      <= in.v;
      m1_x_ff      <= x_prod[32:16];
      m1_y_ff      <= y_prod[32:16];
      m1_z_ff      <= z_prod[32:16];
      m2_red_ff    <= to_byte(r_val);
      m2_green_ff  <= to_byte(g_val);
      m2_blue_ff   <= to_byte(b_val);
   end

   assign out_valid = m2_vld_ff;
   assign out_red   = m2_red_ff;
   assign out_green = m2_green_ff;
   assign out_blue  = m2_blue_ff;

endmodule

// ----- hw/rtl/db_level_heat_color_top.sv -----
// db_level_heat_color_top: heat-map color for an attenuation in dB.
// Instantiates dlhc_front, dlhc_div, dlhc_hue and dlhc_mix; uses dlhc_pkg.
//
// Usage:
//  - Input: drive req_attenuation_db and raise start; the item is taken at the
//    rising edge where start is high and busy is low. busy is high only while
//    reset is held (and the cycle after), so one item can be taken per cycle.
//  - Result: rsp_red/green/blue are valid for exactly one cycle with rsp_strobe.
//    The receiver cannot stall; every taken item yields one result, in order.
//  - Pipeline: the result is registered through 2 front stages, 17 divider
//    stages, 5 hue stages and 2 mix stages.
//    Throughput: one item per cycle while busy is low, set by the fully
//    pipelined dividers that produce one quotient bit per stage.
//  - Config: csr_range_db is written when csr_valid is high (csr_ready is
//    always high). A range of 0 is used as 1. Each item carries the range it
//    saw at entry, so a write only affects items taken after it.
//  - Reset (synchronous, active high): range returns to 100 dB, all pipeline
//    valid bits clear, no result is produced for items in flight.
module db_level_heat_color_top (
   input  logic                           clock,
   input  logic                           reset,
   // item in
   input  logic                           start,
   output logic                           busy,
   input  logic [dlhc_pkg::ATT_W-1:0]     req_attenuation_db,
   // result out
   output logic                           rsp_strobe,
   output logic [dlhc_pkg::CHAN_W-1:0]    rsp_red,
   output logic [dlhc_pkg::CHAN_W-1:0]    rsp_green,
   output logic [dlhc_pkg::CHAN_W-1:0]    rsp_blue,
   // range register
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [dlhc_pkg::RANGE_W-1:0]   csr_range_db
);
   import dlhc_pkg::*;

   logic               accept;
   logic [RANGE_W-1:0] range_ff;
   logic [RANGE_W-1:0] range_in;
   logic               busy_ff;

   front_to_div_type   front_out;
   div_to_hue_type     div_out;
   hue_to_mix_type     hue_out;

   assign csr_ready = 1'b1;
   assign accept    = start & ~busy_ff;
   assign busy      = busy_ff;

   always_comb begin
      range_in = range_ff;
      if (csr_valid && csr_ready) begin
         range_in = csr_range_db;
      end
   end

   // busy covers the reset window only
   always_ff @(posedge clock) begin
      if (reset) begin
         range_ff <= RANGE_RESET;
         busy_ff  <= 1'b1;
      end else begin
         range_ff <= range_in;
         busy_ff  <= 1'b0;
      end
   end

   // saturate, level, products for the dividers
   dlhc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .in_att   (req_attenuation_db),
      .in_range (range_ff),
      .out      (front_out)
   );

   // tmp and V, one quotient bit per stage
   dlhc_div u_div (
      .clock (clock),
      .reset (reset),
      .in    (front_out),
      .out   (div_out)
   );

   // hue, sector, C and the saturation products
   dlhc_hue u_hue (
      .clock (clock),
      .reset (reset),
      .in    (div_out),
      .out   (hue_out)
   );

   // channel values, sector mux, byte scaling; output register
   dlhc_mix u_mix (
      .clock     (clock),
      .reset     (reset),
      .in        (hue_out),
      .out_valid (rsp_strobe),
      .out_red   (rsp_red),
      .out_green (rsp_green),
      .out_blue  (rsp_blue)
   );

   // every taken item comes out after the fixed latency
   a_item_out: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##PIPE_LATENCY rsp_strobe)
      else $error("taken item did not produce a result on time");

   // no result without an item taken at the matching edge
   a_no_stray: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, PIPE_LATENCY))
      else $error("result strobe without a matching item");

   // quotients stay within their ranges: V <= 1.0, tmp <= 180
   a_div_range: assert property (@(posedge clock) disable iff (reset)
      div_out.valid |-> (div_out.v <= ONE_Q16 && div_out.tmp <= HUE_SPAN))
      else $error("divider quotient out of range");

endmodule
